@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, codes and constants for the paragraph property scanner.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int CodeWidth  = 16;
   localparam int ValueWidth = 24;
   localparam int AccWidth   = 32;
   localparam int OffWidth   = 32;
   localparam int CsrIdxWidth = 2;

   // parser phases
   localparam logic [2:0] PH_STYLE_A  = 3'd0;
   localparam logic [2:0] PH_STYLE_B  = 3'd1;
   localparam logic [2:0] PH_CODE_LO  = 3'd2;
   localparam logic [2:0] PH_CODE_HI  = 3'd3;
   localparam logic [2:0] PH_FIXED    = 3'd4;
   localparam logic [2:0] PH_VAR_LEN  = 3'd5;
   localparam logic [2:0] PH_VAR_SKIP = 3'd6;

   localparam logic [2:0] VAR_SIZE_CLASS = 3'd6;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] REG_CODE_FIRST  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_CODE_SECOND = 2'd1;
   localparam logic [CsrIdxWidth-1:0] REG_VALUE       = 2'd2;

   localparam logic [CodeWidth-1:0]  RST_CODE_FIRST  = 16'h2403;
   localparam logic [CodeWidth-1:0]  RST_CODE_SECOND = 16'h2416;
   localparam logic [ValueWidth-1:0] RST_VALUE       = 24'h000001;

   typedef struct packed {
      logic [CodeWidth-1:0]  code_first;
      logic [CodeWidth-1:0]  code_second;
      logic [ValueWidth-1:0] value;
   } cfg_type;

   typedef struct packed {
      logic is_centered;
      logic cut_short;
   } flags_type;

   // operand bytes per size class; variable class reads a length byte instead
   function automatic logic [7:0] size_of_class(input logic [2:0] cls);
      logic [7:0] sz;
      case (cls)
         3'd0:    sz = 8'd1;
         3'd1:    sz = 8'd1;
         3'd2:    sz = 8'd2;
         3'd3:    sz = 8'd4;
         3'd4:    sz = 8'd2;
         3'd5:    sz = 8'd2;
         3'd6:    sz = 8'd0;
         default: sz = 8'd3;
      endcase
      return sz;
   endfunction

endpackage

@@ rtl/pps_csr.sv @@
// ----------------------------------------------------------------------------
// pps_csr
// Match code and match value registers, written through the csr channel.
// ----------------------------------------------------------------------------
module pps_csr
   import pps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ValueWidth-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CODE_FIRST:  cfg_in.code_first  = csr_wdata[CodeWidth-1:0];
            REG_CODE_SECOND: cfg_in.code_second = csr_wdata[CodeWidth-1:0];
            REG_VALUE:       cfg_in.value       = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_first  <= RST_CODE_FIRST;
         cfg_ff.code_second <= RST_CODE_SECOND;
         cfg_ff.value       <= RST_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/pps_parser.sv @@
// ----------------------------------------------------------------------------
// pps_parser
// Running parse state of the property list; one byte per accepted beat.
// Flags for the paragraph are presented for the current byte.
// ----------------------------------------------------------------------------
module pps_parser
   import pps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] list_byte,
   input  logic       last_byte,
   input  cfg_type    cfg,
   output flags_type  flags
);

   logic [2:0]           phase_ff,  phase_in;
   logic [1:0]           count_ff,  count_in;
   logic [CodeWidth-1:0] code_ff,   code_in;
   logic [AccWidth-1:0]  acc_ff,    acc_in;
   logic [7:0]           left_ff,   left_in;
   logic                 seen_ff,   seen_in;

   logic [2:0]           phase_nx;
   logic [1:0]           count_nx;
   logic [CodeWidth-1:0] code_nx;
   logic [AccWidth-1:0]  acc_nx;
   logic [7:0]           left_nx;
   logic                 seen_nx;
   logic [AccWidth-1:0]  acc_merged;
   logic [7:0]           left_dec;
   logic                 code_hit;

   assign acc_merged = acc_ff | ({{(AccWidth-8){1'b0}}, list_byte} << {count_ff, 3'b000});
   assign left_dec   = left_ff - 8'd1;
   assign code_hit   = (code_ff == cfg.code_first) || (code_ff == cfg.code_second);

   always_comb begin
      phase_nx = phase_ff;
      count_nx = count_ff;
      code_nx  = code_ff;
      acc_nx   = acc_ff;
      left_nx  = left_ff;
      seen_nx  = seen_ff;
      case (phase_ff)
         PH_STYLE_B: begin
            phase_nx = PH_CODE_LO;
         end
         PH_CODE_LO: begin
            code_nx  = {8'h00, list_byte};
            phase_nx = PH_CODE_HI;
         end
         PH_CODE_HI: begin
            code_nx = {list_byte, code_ff[7:0]};
            if (list_byte[7:5] == VAR_SIZE_CLASS) begin
               phase_nx = PH_VAR_LEN;
            end else begin
               left_nx  = size_of_class(list_byte[7:5]);
               count_nx = 2'd0;
               acc_nx   = '0;
               phase_nx = PH_FIXED;
            end
         end
         PH_FIXED: begin
            acc_nx   = acc_merged;
            count_nx = count_ff + 2'd1;
            left_nx  = left_dec;
            if (left_dec == 8'd0) begin
               if (code_hit && (acc_merged == {{(AccWidth-ValueWidth){1'b0}}, cfg.value})) begin
                  seen_nx = 1'b1;
               end
               phase_nx = PH_CODE_LO;
            end
         end
         PH_VAR_LEN: begin
            left_nx  = list_byte;
            phase_nx = (list_byte != 8'd0) ? PH_VAR_SKIP : PH_CODE_LO;
         end
         PH_VAR_SKIP: begin
            left_nx = left_dec;
            if (left_dec == 8'd0) begin
               phase_nx = PH_CODE_LO;
            end
         end
         default: begin
            phase_nx = PH_STYLE_B;
         end
      endcase
   end

   assign flags.is_centered = seen_nx;
   assign flags.cut_short   = (phase_nx != PH_CODE_LO);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      code_in  = code_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      seen_in  = seen_ff;
      if (take) begin
         if (last_byte) begin
            phase_in = PH_STYLE_A;
            count_in = '0;
            code_in  = '0;
            acc_in   = '0;
            left_in  = '0;
            seen_in  = 1'b0;
         end else begin
            phase_in = phase_nx;
            count_in = count_nx;
            code_in  = code_nx;
            acc_in   = acc_nx;
            left_in  = left_nx;
            seen_in  = seen_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STYLE_A;
         count_ff <= '0;
         code_ff  <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         code_ff  <= code_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

@@ rtl/paragraph_property_scanner.sv @@
// ----------------------------------------------------------------------------
// paragraph_property_scanner
// Byte-serial scanner of one paragraph's style index and property list.
// ----------------------------------------------------------------------------
// Takes one list byte per beat, one beat per cycle while req_ready is high:
// the parse state updates in the cycle a byte is accepted and the beat
// carrying last_byte loads the result register, which drives rsp_ from the
// next cycle. req_ready drops only while that result register is full and
// rsp_ready is low. After each last byte the parser returns to the style-skip
// phase for the next paragraph; csr writes are registered and taken at any time.
// ----------------------------------------------------------------------------
module paragraph_property_scanner
   import pps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_list_byte,
   input  logic                   req_last_byte,
   input  logic [OffWidth-1:0]    req_para_start,
   input  logic [OffWidth-1:0]    req_para_end,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OffWidth-1:0]    rsp_range_start,
   output logic [OffWidth-1:0]    rsp_range_end,
   output logic                   rsp_is_centered,
   output logic                   rsp_cut_short,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ValueWidth-1:0]  csr_wdata
);

   cfg_type   cfg;
   flags_type flags;
   logic      take;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OffWidth-1:0] start_ff, start_in;
   logic [OffWidth-1:0] end_ff,   end_in;
   flags_type           flags_ff, flags_in;

   pps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   pps_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .list_byte (req_list_byte),
      .last_byte (req_last_byte),
      .cfg       (cfg),
      .flags     (flags)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      flags_in     = flags_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && req_last_byte) begin
         rsp_valid_in = 1'b1;
         start_in     = req_para_start;
         end_in       = req_para_end;
         flags_in     = flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      flags_ff <= flags_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_start = start_ff;
   assign rsp_range_end   = end_ff;
   assign rsp_is_centered = flags_ff.is_centered;
   assign rsp_cut_short   = flags_ff.cut_short;

endmodule
